// File: rtl/core/lpw_pkg.sv
// lidar point-to-world package: field widths, register codes, reset values,
// cordic arctangent table and shared fixed-point helpers
// no dependencies
`timescale 1ns / 1ps

package lpw_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int RANGE_W   = 20;
  localparam int VANGLE_W  = 16;
  localparam int HANGLE_W  = 17;
  localparam int INTENS_W  = 16;
  localparam int WORLD_W   = 24;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam int TRIG_W = 18;  // q16 cos / sin after quadrant fold
  localparam int COEF_W = 20;  // q14 rotation matrix entry

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_SCALE   = 4'd0,
    REG_SENSOR_QUAT   = 4'd1,
    REG_SENSOR_OFFSET = 4'd2,
    REG_MOUNT_ROW0    = 4'd3,
    REG_MOUNT_ROW1    = 4'd4,
    REG_MOUNT_ROW2    = 4'd5,
    REG_BODY_QUAT     = 4'd6,
    REG_BODY_OFFSET   = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  localparam logic [31:0] RANGE_SCALE_RST = 32'h0001_0000;
  localparam logic [63:0] QUAT_RST        = 64'h4000_0000_0000_0000;
  localparam logic [59:0] OFFSET_RST      = 60'h0;
  localparam logic [63:0] MOUNT_ROW0_RST  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] MOUNT_ROW1_RST  = 64'h0000_4000_0000_0000;
  localparam logic [63:0] MOUNT_ROW2_RST  = 64'h0000_0000_4000_0000;

  // row-major 3x3, entry 3*row+col
  typedef logic [8:0][COEF_W-1:0] mat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2F9;
      5'd15: r = 32'h0000_517D;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A30;
      5'd19: r = 32'h0000_0518;
      5'd20: r = 32'h0000_028C;
      5'd21: r = 32'h0000_0146;
      5'd22: r = 32'h0000_00A3;
      5'd23: r = 32'h0000_0051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7F_FFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // round half up by 2^13 into a q14 coefficient
  function automatic logic [COEF_W-1:0] rnd13(input logic signed [32:0] a);
    logic signed [32:0] t;
    t = a + 33'sd4096;
    return t[32:13];
  endfunction

  // quaternion w,x,y,z (q2.14, w on top) to rotation matrix
  function automatic mat_t quat_to_mat(input logic [63:0] q);
    logic signed [15:0] w, x, y, z;
    logic signed [32:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    mat_t m;
    w  = q[63:48];
    x  = q[47:32];
    y  = q[31:16];
    z  = q[15:0];
    xx = x * x;
    yy = y * y;
    zz = z * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    wx = w * x;
    wy = w * y;
    wz = w * z;
    m[0] = 20'sd16384 - rnd13(yy + zz);
    m[1] = rnd13(xy - wz);
    m[2] = rnd13(xz + wy);
    m[3] = rnd13(xy + wz);
    m[4] = 20'sd16384 - rnd13(xx + zz);
    m[5] = rnd13(yz - wx);
    m[6] = rnd13(xz - wy);
    m[7] = rnd13(yz + wx);
    m[8] = 20'sd16384 - rnd13(xx + yy);
    return m;
  endfunction

endpackage

// File: rtl/core/lidar_point_to_world_unit.sv
// throughput: one point per cycle; an output stall holds every stage in place
// the two cordic chains (one stage per rotation) set the depth of the pipeline
// reset: pipeline emptied, registers back to unit scale, identity rotations, zero offsets
// a new quaternion reaches the datapath matrices in the cycle after its write
// depends on lpw_pkg and lpw_sincos
`timescale 1ns / 1ps

module lidar_point_to_world_unit #(
  parameter int CORDIC_STAGES = lpw_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // range_raw[19:0], vertical_angle[35:20], horizontal_angle[52:36],
  // intensity_in[68:53], zero pad
  input  logic [lpw_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // world_x[23:0], world_y[47:24], world_z[71:48], intensity_out[87:72]
  output logic [lpw_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lpw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lpw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int LAT  = CORDIC_STAGES + 5;
  localparam int LAST = LAT + 10;

  // configuration
  logic [31:0] range_scale_q;
  logic [63:0] sensor_quat_q, body_quat_q;
  logic [59:0] sensor_offset_q, body_offset_q;
  logic [63:0] mount_q [3];
  lpw_pkg::mat_t smat_q, bmat_q;

  logic adv;
  logic [LAST:0] vld_q;

  logic [lpw_pkg::RANGE_W-1:0]         rng_s0_q;
  logic signed [lpw_pkg::HANGLE_W-1:0] va_s0_q, ha_s0_q;
  logic [lpw_pkg::INTENS_W-1:0]        int_s0_q;
  logic [lpw_pkg::INTENS_W-1:0]        int_dly_q [LAST];

  logic [51:0] rprod_q;
  logic [52:0] rrnd;
  logic [30:0] r_d, r_q;
  logic [30:0] r_dly_q [LAT-2];

  logic signed [lpw_pkg::TRIG_W-1:0] cv, sv, ch, sh;
  logic signed [lpw_pkg::TRIG_W-1:0] ch_dly_q [6];
  logic signed [lpw_pkg::TRIG_W-1:0] sh_dly_q [6];

  logic signed [49:0] pc_q, ps_q;
  logic signed [49:0] pcr, psr;
  logic signed [33:0] v0_q, v1_q;

  logic signed [53:0] sp_q [3][2];
  logic signed [54:0] s_acc [3];
  logic signed [32:0] s_add [3];
  logic signed [31:0] s_rot [3];
  logic signed [31:0] sv_d [3];
  logic signed [31:0] sv_q [3];

  logic signed [47:0] mp_q [3][3];
  logic signed [49:0] m_acc [3];
  logic signed [36:0] m_add [3];
  logic signed [31:0] f_d [3];
  logic signed [31:0] f_q [3];

  logic signed [49:0] hp_q [4];
  logic signed [50:0] hx_acc, hy_acc;
  logic signed [31:0] hv_d [2];
  logic signed [31:0] hv_q [2];
  logic signed [31:0] f2_l_q, f2_m_q;
  logic signed [31:0] bin [3];

  logic signed [51:0] bp_q [3][3];
  logic signed [53:0] b_acc [3];
  logic signed [32:0] b_add [3];
  logic signed [31:0] b_rot [3];
  logic signed [lpw_pkg::WORLD_W-1:0] w_d [3];
  logic signed [lpw_pkg::WORLD_W-1:0] w_q [3];

  assign cfg_ready_o     = 1'b1;
  assign adv             = !vld_q[LAST] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[LAST];
  assign m_axis_tdata_o  = {int_dly_q[LAST-1], w_q[2], w_q[1], w_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_scale_q   <= lpw_pkg::RANGE_SCALE_RST;
      sensor_quat_q   <= lpw_pkg::QUAT_RST;
      sensor_offset_q <= lpw_pkg::OFFSET_RST;
      mount_q[0]      <= lpw_pkg::MOUNT_ROW0_RST;
      mount_q[1]      <= lpw_pkg::MOUNT_ROW1_RST;
      mount_q[2]      <= lpw_pkg::MOUNT_ROW2_RST;
      body_quat_q     <= lpw_pkg::QUAT_RST;
      body_offset_q   <= lpw_pkg::OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lpw_pkg::REG_RANGE_SCALE:   range_scale_q   <= cfg_data_i[31:0];
        lpw_pkg::REG_SENSOR_QUAT:   sensor_quat_q   <= cfg_data_i;
        lpw_pkg::REG_SENSOR_OFFSET: sensor_offset_q <= cfg_data_i[59:0];
        lpw_pkg::REG_MOUNT_ROW0:    mount_q[0]      <= cfg_data_i;
        lpw_pkg::REG_MOUNT_ROW1:    mount_q[1]      <= cfg_data_i;
        lpw_pkg::REG_MOUNT_ROW2:    mount_q[2]      <= cfg_data_i;
        lpw_pkg::REG_BODY_QUAT:     body_quat_q     <= cfg_data_i;
        lpw_pkg::REG_BODY_OFFSET:   body_offset_q   <= cfg_data_i[59:0];
        default: ;
      endcase
    end
  end

  // matrices follow quaternions; keeping them static while items flow is up to the user
  always_ff @(posedge clk_i) begin
    smat_q <= lpw_pkg::quat_to_mat(sensor_quat_q);
    bmat_q <= lpw_pkg::quat_to_mat(body_quat_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], s_axis_tvalid_i};
    end
  end

  // input stage and range scaling
  assign rrnd = {1'b0, rprod_q} + 53'd32768;
  assign r_d  = (|rrnd[52:47]) ? 31'h7FFF_FFFF : rrnd[46:16];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rng_s0_q <= s_axis_tdata_i[19:0];
      va_s0_q  <= 17'($signed(s_axis_tdata_i[35:20]));
      ha_s0_q  <= $signed(s_axis_tdata_i[52:36]);
      int_s0_q <= s_axis_tdata_i[68:53];
      rprod_q  <= rng_s0_q * range_scale_q;
      r_q      <= r_d;
      r_dly_q[0]   <= r_q;
      int_dly_q[0] <= int_s0_q;
      for (int i = 1; i < LAT-2; i++) begin
        r_dly_q[i] <= r_dly_q[i-1];
      end
      for (int i = 1; i < LAST; i++) begin
        int_dly_q[i] <= int_dly_q[i-1];
      end
    end
  end

  lpw_sincos #(.STAGES(CORDIC_STAGES)) u_sincos_v (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (va_s0_q),
    .cos_o   (cv),
    .sin_o   (sv)
  );

  lpw_sincos #(.STAGES(CORDIC_STAGES)) u_sincos_h (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (ha_s0_q),
    .cos_o   (ch),
    .sin_o   (sh)
  );

  // scan plane point, sensor rotation and offset, mount transform
  always_comb begin
    pcr = pc_q + 50'sd32768;
    psr = ps_q + 50'sd32768;
    for (int k = 0; k < 3; k++) begin
      s_acc[k] = 55'(sp_q[k][0]) + 55'(sp_q[k][1]) + 55'sd8192;
      s_rot[k] = lpw_pkg::sat32(64'($signed(s_acc[k][54:14])));
      s_add[k] = 33'(s_rot[k]) + 33'($signed(sensor_offset_q[59-20*k -: 20]));
      sv_d[k]  = lpw_pkg::sat32(64'(s_add[k]));
      m_acc[k] = 50'(mp_q[k][0]) + 50'(mp_q[k][1]) + 50'(mp_q[k][2]) + 50'sd8192;
      m_add[k] = 37'($signed(m_acc[k][49:14])) + 37'($signed(mount_q[k][15:0]));
      f_d[k]   = lpw_pkg::sat32(64'(m_add[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_q <= $signed({1'b0, r_dly_q[LAT-3]}) * cv;
      ps_q <= $signed({1'b0, r_dly_q[LAT-3]}) * sv;
      v0_q <= pcr[49:16];
      v1_q <= psr[49:16];
      for (int k = 0; k < 3; k++) begin
        sp_q[k][0] <= $signed(smat_q[3*k])   * v0_q;
        sp_q[k][1] <= $signed(smat_q[3*k+1]) * v1_q;
        sv_q[k]    <= sv_d[k];
        for (int j = 0; j < 3; j++) begin
          mp_q[k][j] <= $signed(mount_q[k][63-16*j -: 16]) * sv_q[j];
        end
        f_q[k] <= f_d[k];
      end
    end
  end

  // horizontal turn about z
  always_comb begin
    hx_acc = 51'(hp_q[0]) - 51'(hp_q[1]) + 51'sd32768;
    hy_acc = 51'(hp_q[2]) + 51'(hp_q[3]) + 51'sd32768;
    hv_d[0] = lpw_pkg::sat32(64'($signed(hx_acc[50:16])));
    hv_d[1] = lpw_pkg::sat32(64'($signed(hy_acc[50:16])));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch_dly_q[0] <= ch;
      sh_dly_q[0] <= sh;
      for (int i = 1; i < 6; i++) begin
        ch_dly_q[i] <= ch_dly_q[i-1];
        sh_dly_q[i] <= sh_dly_q[i-1];
      end
      hp_q[0] <= f_q[0] * ch_dly_q[5];
      hp_q[1] <= f_q[1] * sh_dly_q[5];
      hp_q[2] <= f_q[0] * sh_dly_q[5];
      hp_q[3] <= f_q[1] * ch_dly_q[5];
      f2_l_q  <= f_q[2];
      hv_q[0] <= hv_d[0];
      hv_q[1] <= hv_d[1];
      f2_m_q  <= f2_l_q;
    end
  end

  // body rotation, body offset, final clamp to 24 bits
  assign bin[0] = hv_q[0];
  assign bin[1] = hv_q[1];
  assign bin[2] = f2_m_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_acc[k] = 54'(bp_q[k][0]) + 54'(bp_q[k][1]) + 54'(bp_q[k][2]) + 54'sd8192;
      b_rot[k] = lpw_pkg::sat32(64'($signed(b_acc[k][53:14])));
      b_add[k] = 33'(b_rot[k]) + 33'($signed(body_offset_q[59-20*k -: 20]));
      w_d[k]   = lpw_pkg::sat24(64'(b_add[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          bp_q[k][j] <= $signed(bmat_q[3*k+j]) * bin[j];
        end
        w_q[k] <= w_d[k];
      end
    end
  end

endmodule

// File: rtl/core/lpw_sincos.sv
// pipelined sine / cosine of an angle in hundredths of a degree, q16 out
// wrap, phase scaling, quadrant split, one cordic rotation per stage
// depends on lpw_pkg
`timescale 1ns / 1ps

module lpw_sincos #(
  parameter int STAGES = lpw_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lpw_pkg::HANGLE_W-1:0] angle_i,
  output logic signed [lpw_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [lpw_pkg::TRIG_W-1:0]   sin_o
);

  localparam logic signed [31:0] X0 = 32'sh26DD_3B6A;

  logic signed [17:0] a18, plus1, plus2, minus1;
  logic [15:0]        wrap_d, wrap_q;
  logic [31:0]        pa_d, pa_q, pa2_q;
  logic [24:0]        u_d, u_q;
  logic [50:0]        recip_prod;
  logic [14:0]        qd_d, qd_q;
  logic [31:0]        phase, phase_off, resid;
  logic [1:0]         quad;

  logic signed [31:0] cx_q [STAGES+1];
  logic signed [31:0] cy_q [STAGES+1];
  logic signed [31:0] cz_q [STAGES+1];
  logic [1:0]         cquad_q [STAGES+1];

  logic signed [31:0] xr, yr;
  logic signed [17:0] cq, sq;
  logic signed [17:0] cos_d, sin_d;

  // wrap into [0, 36000)
  always_comb begin
    a18    = 18'(angle_i);
    plus1  = a18 + 18'sd36000;
    plus2  = a18 + 18'sd72000;
    minus1 = a18 - 18'sd36000;
    if (a18 < 0) begin
      wrap_d = (plus1 < 0) ? plus2[15:0] : plus1[15:0];
    end else if (a18 >= 18'sd36000) begin
      wrap_d = minus1[15:0];
    end else begin
      wrap_d = a18[15:0];
    end
  end

  // phase = m*2^32/36000 rounded: m*119304 + floor((m*728 + 562) / 1125)
  assign pa_d       = wrap_q * 17'd119304;
  assign u_d        = wrap_q * 10'd728 + 25'd562;
  assign recip_prod = u_q * 26'd61083980;
  assign qd_d       = recip_prod[50:36];

  assign phase     = pa2_q + 32'(qd_q);
  assign phase_off = phase + 32'h2000_0000;
  assign quad      = phase_off[31:30];
  assign resid     = phase - {quad, 30'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_q     <= wrap_d;
      pa_q       <= pa_d;
      u_q        <= u_d;
      pa2_q      <= pa_q;
      qd_q       <= qd_d;
      cx_q[0]    <= X0;
      cy_q[0]    <= 32'sd0;
      cz_q[0]    <= $signed(resid);
      cquad_q[0] <= quad;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cquad_q[i+1] <= cquad_q[i];
        if (cz_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - $signed(lpw_pkg::atan_turn(5'(i)));
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + $signed(lpw_pkg::atan_turn(5'(i)));
        end
      end
    end
  end

  assign xr = cx_q[STAGES] + 32'sd8192;
  assign yr = cy_q[STAGES] + 32'sd8192;
  assign cq = xr[31:14];
  assign sq = yr[31:14];

  always_comb begin
    case (cquad_q[STAGES])
      lpw_pkg::QUAD_I: begin
        cos_d = cq;
        sin_d = sq;
      end
      lpw_pkg::QUAD_II: begin
        cos_d = -sq;
        sin_d = cq;
      end
      lpw_pkg::QUAD_III: begin
        cos_d = -cq;
        sin_d = -sq;
      end
      lpw_pkg::QUAD_IV: begin
        cos_d = sq;
        sin_d = -cq;
      end
      default: begin
        cos_d = cq;
        sin_d = sq;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end

endmodule

// File: dv/lidar_point_to_world_unit_tb.sv
// testbench for lidar_point_to_world_unit: streams lidar returns through the
// block under several register settings and checks each world point against
// a bit-true predictor; depends on lpw_pkg and the unit's rtl
`timescale 1ns / 1ps

module lidar_point_to_world_unit_tb;

  localparam int STAGES  = 16;
  localparam int LATENCY = STAGES + 15;

  typedef struct packed {
    logic [15:0] intensity;
    logic [23:0] wz;
    logic [23:0] wy;
    logic [23:0] wx;
  } world_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [lpw_pkg::IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [lpw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lpw_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [lpw_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  lidar_point_to_world_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the register file
  logic [63:0] regs [8];
  world_point_t expected_points [$];
  int n_errors = 0;
  int n_points = 0;
  int n_sent = 0;
  int hold_cycles = 0;  // long receiver hold-off when non-zero
  bit steady_sink = 0;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  function automatic longint rnd_sh(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint field_s(logic [63:0] v, int w, int lsb);
    logic [63:0] f;
    longint r;
    f = (v >> lsb) & ((64'd1 << w) - 1);
    r = longint'(f);
    if (f[w-1]) r -= 64'sd1 <<< w;
    return r;
  endfunction

  task automatic cordic_trig(input longint ang, output longint c, output longint s);
    longint m, z, x, y, dx, dy, cq, sq;
    logic [31:0] phase, d;
    logic [1:0] q;
    m = ang % 36000;
    if (m < 0) m += 36000;
    phase = 32'((((64'(m)) << 32) + 18000) / 36000);
    q = 2'((phase + 32'h20000000) >> 30);
    d = phase - (32'(q) << 30);
    z = d[31] ? longint'(d) - (64'sd1 <<< 32) : longint'(d);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    cq = rnd_sh(x, 14);
    sq = rnd_sh(y, 14);
    case (lpw_pkg::quad_e'(q))
      lpw_pkg::QUAD_I:   begin c = cq;  s = sq;  end
      lpw_pkg::QUAD_II:  begin c = -sq; s = cq;  end
      lpw_pkg::QUAD_III: begin c = -cq; s = -sq; end
      default:           begin c = sq;  s = -cq; end
    endcase
  endtask

  task automatic quat_rotate(input logic [63:0] qr, inout longint v [3]);
    longint w, x, y, z, m [3][3], o [3];
    w = field_s(qr, 16, 48); x = field_s(qr, 16, 32);
    y = field_s(qr, 16, 16); z = field_s(qr, 16, 0);
    m[0][0] = 16384 - rnd_sh(y * y + z * z, 13);
    m[0][1] = rnd_sh(x * y - w * z, 13);
    m[0][2] = rnd_sh(x * z + w * y, 13);
    m[1][0] = rnd_sh(x * y + w * z, 13);
    m[1][1] = 16384 - rnd_sh(x * x + z * z, 13);
    m[1][2] = rnd_sh(y * z - w * x, 13);
    m[2][0] = rnd_sh(x * z - w * y, 13);
    m[2][1] = rnd_sh(y * z + w * x, 13);
    m[2][2] = 16384 - rnd_sh(x * x + y * y, 13);
    for (int k = 0; k < 3; k++)
      o[k] = clamp(rnd_sh(m[k][0] * v[0] + m[k][1] * v[1] + m[k][2] * v[2], 14), 32);
    v = o;
  endtask

  task automatic shift_by(input logic [63:0] off, inout longint v [3]);
    v[0] = clamp(v[0] + field_s(off, 20, 40), 32);
    v[1] = clamp(v[1] + field_s(off, 20, 20), 32);
    v[2] = clamp(v[2] + field_s(off, 20, 0), 32);
  endtask

  task automatic predict_world(input logic [lpw_pkg::IN_DATA_W-1:0] d,
                               output world_point_t p);
    longint r, c, s, v [3], f [3], acc;
    logic [63:0] row;
    r = clamp(rnd_sh(longint'(64'(d[19:0]) * regs[lpw_pkg::REG_RANGE_SCALE]), 16), 32);
    cordic_trig(longint'($signed(d[35:20])), c, s);
    v[0] = rnd_sh(r * c, 16);
    v[1] = rnd_sh(r * s, 16);
    v[2] = 0;
    quat_rotate(regs[lpw_pkg::REG_SENSOR_QUAT], v);
    shift_by(regs[lpw_pkg::REG_SENSOR_OFFSET], v);
    for (int k = 0; k < 3; k++) begin
      row = regs[lpw_pkg::REG_MOUNT_ROW0 + k];
      acc = field_s(row, 16, 48) * v[0] + field_s(row, 16, 32) * v[1]
          + field_s(row, 16, 16) * v[2];
      f[k] = clamp(rnd_sh(acc, 14) + field_s(row, 16, 0), 32);
    end
    cordic_trig(longint'($signed(d[52:36])), c, s);
    v[0] = clamp(rnd_sh(f[0] * c - f[1] * s, 16), 32);
    v[1] = clamp(rnd_sh(f[0] * s + f[1] * c, 16), 32);
    v[2] = f[2];
    quat_rotate(regs[lpw_pkg::REG_BODY_QUAT], v);
    shift_by(regs[lpw_pkg::REG_BODY_OFFSET], v);
    p.wx = 24'(clamp(v[0], 24));
    p.wy = 24'(clamp(v[1], 24));
    p.wz = 24'(clamp(v[2], 24));
    p.intensity = d[68:53];
  endtask

  task automatic reset_regs();
    regs[lpw_pkg::REG_RANGE_SCALE]   = 64'(lpw_pkg::RANGE_SCALE_RST);
    regs[lpw_pkg::REG_SENSOR_QUAT]   = lpw_pkg::QUAT_RST;
    regs[lpw_pkg::REG_SENSOR_OFFSET] = 64'(lpw_pkg::OFFSET_RST);
    regs[lpw_pkg::REG_MOUNT_ROW0]    = lpw_pkg::MOUNT_ROW0_RST;
    regs[lpw_pkg::REG_MOUNT_ROW1]    = lpw_pkg::MOUNT_ROW1_RST;
    regs[lpw_pkg::REG_MOUNT_ROW2]    = lpw_pkg::MOUNT_ROW2_RST;
    regs[lpw_pkg::REG_BODY_QUAT]     = lpw_pkg::QUAT_RST;
    regs[lpw_pkg::REG_BODY_OFFSET]   = 64'(lpw_pkg::OFFSET_RST);
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lpw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == lpw_pkg::REG_SENSOR_OFFSET || idx == lpw_pkg::REG_BODY_OFFSET)
      regs[idx] = val & 64'h0FFF_FFFF_FFFF_FFFF;
    else if (idx == lpw_pkg::REG_RANGE_SCALE)
      regs[idx] = val & 64'hFFFF_FFFF;
    else if (idx <= lpw_pkg::REG_BODY_OFFSET)
      regs[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    repeat (2) @(negedge clk_i);  // quaternion matrices settle
  endtask

  function automatic logic [lpw_pkg::IN_DATA_W-1:0] pack_return(logic [19:0] rng,
      logic [15:0] va, logic [16:0] ha, logic [15:0] inten);
    return {3'b0, inten, ha, va, rng};
  endfunction

  // sends one return; the caller decides on gaps
  task automatic send_return(input logic [lpw_pkg::IN_DATA_W-1:0] d);
    world_point_t p;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_world(d, p);
    expected_points.insert(expected_points.size(), p);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [lpw_pkg::IN_DATA_W-1:0] random_return(bit wild);
    logic [19:0] rng;
    logic [15:0] va;
    logic [16:0] ha;
    rng = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 63)) : 20'($urandom);
    if (wild) begin
      va = 16'($urandom);
      ha = 17'($urandom);
    end else begin
      va = 16'($urandom_range(0, 36000) - 18000);
      ha = 17'($urandom_range(0, 72000) - 36000);
    end
    return pack_return(rng, va, ha, 16'($urandom));
  endfunction

  task automatic send_burst_stream(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      send_return(random_return($urandom_range(0, 9) == 0));
      burst--;
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  logic [63:0] rand64;
  function automatic logic [63:0] rand_q(int spread);
    logic [63:0] r;
    r = {$urandom, $urandom};
    for (int k = 0; k < 4; k++)
      r[16*k +: 16] = (k == 3) ? 16'(16384 - $urandom_range(0, spread))
                               : 16'($urandom_range(0, 2 * spread) - spread);
    return r;
  endfunction

  task automatic test_directed_extremes();
    logic [15:0] vas [6] = '{16'sd0, 16'sd9000, -16'sd9000, 16'sd18000, -16'sd18000, 16'sd4500};
    logic [16:0] has [6] = '{17'sd0, 17'sd36000, -17'sd36000, 17'sd27000, -17'sd9000, 17'sd13500};
    for (int i = 0; i < 6; i++)
      send_return(pack_return(20'hFFFFF, vas[i], has[i], 16'hFFFF));
    send_return(pack_return(20'h0, 16'h7FFF, 17'h0FFFF, 16'h0));
    send_return(pack_return(20'h80000, 16'h8000, 17'h10000, 16'h8001));
    send_return(pack_return(20'h1, 16'hFFFF, 17'h1FFFF, 16'h5AA5));
    send_return(pack_return(20'h12345, 16'sd1, 17'sd18000, 16'h1234));
    s_axis_tvalid_i <= 1'b0;
    drain();
  endtask

  task automatic test_saturation();
    write_reg(lpw_pkg::REG_RANGE_SCALE, 64'hFFFF_FFFF);
    write_reg(lpw_pkg::REG_BODY_OFFSET, 64'h7FFFF_7FFFF_80000);
    write_reg(lpw_pkg::REG_MOUNT_ROW0, 64'h7FFF_8000_7FFF_7FFF);
    for (int i = 0; i < 8; i++) send_return(random_return(i[0]));
    s_axis_tvalid_i <= 1'b0;
    drain();
    write_reg(lpw_pkg::REG_SENSOR_QUAT, 64'h7FFF_8000_7FFF_8000);  // far from unit
    write_reg(lpw_pkg::REG_BODY_QUAT, 64'h8000_7FFF_8000_7FFF);
    write_reg(lpw_pkg::REG_SENSOR_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(4'd9, 64'hDEAD);  // unused index
    for (int i = 0; i < 8; i++) send_return(random_return(1'b0));
    s_axis_tvalid_i <= 1'b0;
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(lpw_pkg::REG_RANGE_SCALE,
                64'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000)));
      write_reg(lpw_pkg::REG_SENSOR_QUAT, rand_q(phase == 5 ? 16384 : 3000));
      write_reg(lpw_pkg::REG_SENSOR_OFFSET, {$urandom, $urandom});
      for (int k = 0; k < 3; k++) begin
        rand64 = {$urandom, $urandom};
        write_reg(lpw_pkg::cfg_reg_e'(lpw_pkg::REG_MOUNT_ROW0 + k),
                  rand64 & 64'h7FFF_7FFF_7FFF_FFFF
                  ^ (phase[0] ? 64'h8000_0000_8000_0000 : 64'h0));
      end
      write_reg(lpw_pkg::REG_BODY_QUAT, rand_q(phase == 4 ? 16384 : 3000));
      write_reg(lpw_pkg::REG_BODY_OFFSET, {$urandom, $urandom});
      send_burst_stream(240);
      drain();
    end
  endtask

  task automatic test_backpressure();
    reset_regs_on_dut();
    hold_cycles = 300;
    send_burst_stream(150);
    drain();
  endtask

  task automatic reset_regs_on_dut();
    write_reg(lpw_pkg::REG_RANGE_SCALE, 64'(lpw_pkg::RANGE_SCALE_RST));
    write_reg(lpw_pkg::REG_SENSOR_QUAT, lpw_pkg::QUAT_RST);
    write_reg(lpw_pkg::REG_SENSOR_OFFSET, 64'h0);
    write_reg(lpw_pkg::REG_MOUNT_ROW0, lpw_pkg::MOUNT_ROW0_RST);
    write_reg(lpw_pkg::REG_MOUNT_ROW1, lpw_pkg::MOUNT_ROW1_RST);
    write_reg(lpw_pkg::REG_MOUNT_ROW2, lpw_pkg::MOUNT_ROW2_RST);
    write_reg(lpw_pkg::REG_BODY_QUAT, lpw_pkg::QUAT_RST);
    write_reg(lpw_pkg::REG_BODY_OFFSET, 64'h0);
  endtask

  // long hold-off counted down here, one cycle at a time
  always @(negedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // receiver stall pattern, held off while the countdown runs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
    end else if (steady_sink) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) steady_sink <= ~steady_sink;
  end

  // compare every output transfer with the oldest predicted point
  always @(posedge clk_i) begin
    world_point_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      n_points++;
      if (expected_points.size() == 0) begin
        $error("unexpected output transfer %h", m_axis_tdata_o);
        n_errors++;
      end else begin
        want = expected_points.pop_front();
        if (got.wx !== want.wx) begin
          $error("world_x expected %0d got %0d", $signed(want.wx), $signed(got.wx));
          n_errors++;
        end
        if (got.wy !== want.wy) begin
          $error("world_y expected %0d got %0d", $signed(want.wy), $signed(got.wy));
          n_errors++;
        end
        if (got.wz !== want.wz) begin
          $error("world_z expected %0d got %0d", $signed(want.wz), $signed(got.wz));
          n_errors++;
        end
        if (got.intensity !== want.intensity) begin
          $error("intensity_out expected %0d got %0d", want.intensity, got.intensity);
          n_errors++;
        end
      end
    end
  end

  initial begin
    reset_regs();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_saturation();
    test_random_settings();
    test_backpressure();
    if (expected_points.size() != 0) n_errors++;
    $display("%0d returns sent, %0d points checked over default, extreme and random",
             n_sent, n_points);
    $display("register settings, with one long output hold-off");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/core/lpw_pkg.sv
rtl/core/lpw_sincos.sv
rtl/core/lidar_point_to_world_unit.sv
dv/lidar_point_to_world_unit_tb.sv
